FILE: rtl/core/msprfp_pkg.sv
// Package for the MSP v1 response frame parser.
// Holds sync byte codes, payload depth default and result field widths.
// No dependencies.
`default_nettype none

package msprfp_pkg;

   localparam int MAX_PAYLOAD_DEF = 32;

   localparam logic [7:0] SYNC_DOLLAR = 8'h24;
   localparam logic [7:0] SYNC_M      = 8'h4D;
   localparam logic [7:0] SYNC_DIR    = 8'h3E;

   localparam int BYTE_W   = 8;
   localparam int FLEN_W   = 6;
   localparam int BIDX_W   = 5;

   typedef logic [BYTE_W-1:0] byte_type;

endpackage

`default_nettype wire

FILE: rtl/core/msp_response_frame_parser_top.sv
// After the checksum byte, a frame's results pass the memory read and output registers.
// Input: one byte per cycle while parsing; each result takes a payload memory read
// followed by an output register load that waits while rsp_stall holds the output.
// req_stall stays high while a frame's results are emitted.
// Reset (synchronous, active high) returns the parser to sync hunt and empties the output.
// Depends on msprfp_pkg.
`default_nettype none

module msp_response_frame_parser_top #(
   parameter int MAX_PAYLOAD = msprfp_pkg::MAX_PAYLOAD_DEF
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_stall,
   input  wire  [msprfp_pkg::BYTE_W-1:0]     req_rx_byte,
   output logic                              rsp_valid,
   input  wire                               rsp_stall,
   output logic [msprfp_pkg::BYTE_W-1:0]     rsp_command,
   output logic [msprfp_pkg::FLEN_W-1:0]     rsp_frame_length,
   output logic [msprfp_pkg::BIDX_W-1:0]     rsp_byte_index,
   output logic [msprfp_pkg::BYTE_W-1:0]     rsp_payload_byte,
   output logic                              rsp_empty_frame,
   output logic                              rsp_last
);

   localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int LEN_W = $clog2(MAX_PAYLOAD + 1);
   localparam int BW    = msprfp_pkg::BYTE_W;

   localparam logic [3:0] ST_DOLLAR  = 4'd0;
   localparam logic [3:0] ST_M       = 4'd1;
   localparam logic [3:0] ST_DIR     = 4'd2;
   localparam logic [3:0] ST_LEN     = 4'd3;
   localparam logic [3:0] ST_CMD     = 4'd4;
   localparam logic [3:0] ST_PAYLOAD = 4'd5;
   localparam logic [3:0] ST_CHECK   = 4'd6;
   localparam logic [3:0] ST_EMIT_RD = 4'd7;
   localparam logic [3:0] ST_EMIT_LD = 4'd8;

   logic [3:0]       state_ff, state_in;
   logic [LEN_W-1:0] exp_len_ff, exp_len_in;
   logic [LEN_W-1:0] fill_ff, fill_in;
   logic [BW-1:0]    cmd_ff, cmd_in;
   logic [BW-1:0]    xor_ff, xor_in;
   logic [AW-1:0]    rd_idx_ff, rd_idx_in;
   logic [BW-1:0]    rd_data_ff;

   logic             out_valid_ff, out_valid_in;
   logic [BW-1:0]    out_cmd_ff;
   logic [msprfp_pkg::FLEN_W-1:0] out_len_ff;
   logic [msprfp_pkg::BIDX_W-1:0] out_idx_ff;
   logic [BW-1:0]    out_byte_ff;
   logic             out_empty_ff;
   logic             out_last_ff;

   msprfp_pkg::byte_type payload_mem [MAX_PAYLOAD];

   logic             req_acc;
   logic             mem_wr;
   logic             mem_rd;
   logic             out_free;
   logic             load;
   logic             is_empty;
   logic             is_last;
   logic [LEN_W-1:0] idx_next;
   logic [LEN_W-1:0] fill_next;

   assign req_stall = (state_ff == ST_EMIT_RD) || (state_ff == ST_EMIT_LD);
   assign req_acc   = req_valid && !req_stall;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign is_empty  = (exp_len_ff == '0);
   assign idx_next  = LEN_W'(rd_idx_ff) + LEN_W'(1);
   assign fill_next = fill_ff + LEN_W'(1);
   assign is_last   = is_empty || (idx_next == exp_len_ff);
   assign mem_wr    = req_acc && (state_ff == ST_PAYLOAD);
   assign mem_rd    = (state_ff == ST_EMIT_RD);
   assign load      = (state_ff == ST_EMIT_LD) && out_free;

   always_comb begin
      state_in   = state_ff;
      exp_len_in = exp_len_ff;
      fill_in    = fill_ff;
      cmd_in     = cmd_ff;
      xor_in     = xor_ff;
      rd_idx_in  = rd_idx_ff;
      case (state_ff)
         ST_DOLLAR: begin
            if (req_acc && req_rx_byte == msprfp_pkg::SYNC_DOLLAR) state_in = ST_M;
         end
         ST_M: begin
            if (req_acc) state_in = (req_rx_byte == msprfp_pkg::SYNC_M) ? ST_DIR : ST_DOLLAR;
         end
         ST_DIR: begin
            if (req_acc) state_in = (req_rx_byte == msprfp_pkg::SYNC_DIR) ? ST_LEN : ST_DOLLAR;
         end
         ST_LEN: begin
            if (req_acc) begin
               if (req_rx_byte > BW'(MAX_PAYLOAD)) begin
                  state_in   = ST_DOLLAR;
                  exp_len_in = '0;
                  fill_in    = '0;
                  cmd_in     = '0;
                  xor_in     = '0;
               end else begin
                  exp_len_in = LEN_W'(req_rx_byte);
                  fill_in    = '0;
                  xor_in     = req_rx_byte;
                  state_in   = ST_CMD;
               end
            end
         end
         ST_CMD: begin
            if (req_acc) begin
               cmd_in   = req_rx_byte;
               xor_in   = xor_ff ^ req_rx_byte;
               state_in = is_empty ? ST_CHECK : ST_PAYLOAD;
            end
         end
         ST_PAYLOAD: begin
            if (req_acc) begin
               fill_in = fill_next;
               xor_in  = xor_ff ^ req_rx_byte;
               if (fill_next >= exp_len_ff) state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (req_acc) begin
               rd_idx_in = '0;
               if (xor_ff == req_rx_byte) begin
                  state_in = ST_EMIT_RD;
               end else begin
                  state_in   = ST_DOLLAR;
                  exp_len_in = '0;
                  fill_in    = '0;
                  cmd_in     = '0;
                  xor_in     = '0;
               end
            end
         end
         ST_EMIT_RD: begin
            state_in = ST_EMIT_LD;
         end
         ST_EMIT_LD: begin
            if (load) begin
               if (is_last) begin
                  state_in   = ST_DOLLAR;
                  exp_len_in = '0;
                  fill_in    = '0;
                  cmd_in     = '0;
                  xor_in     = '0;
               end else begin
                  rd_idx_in = rd_idx_ff + AW'(1);
                  state_in  = ST_EMIT_RD;
               end
            end
         end
         default: begin
            state_in   = ST_DOLLAR;
            exp_len_in = '0;
            fill_in    = '0;
            cmd_in     = '0;
            xor_in     = '0;
         end
      endcase
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      if (load) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_DOLLAR;
         exp_len_ff   <= '0;
         fill_ff      <= '0;
         cmd_ff       <= '0;
         xor_ff       <= '0;
         rd_idx_ff    <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         exp_len_ff   <= exp_len_in;
         fill_ff      <= fill_in;
         cmd_ff       <= cmd_in;
         xor_ff       <= xor_in;
         rd_idx_ff    <= rd_idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_wr) begin
         payload_mem[fill_ff[AW-1:0]] <= req_rx_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_rd) begin
         rd_data_ff <= payload_mem[rd_idx_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_cmd_ff   <= cmd_ff;
         out_len_ff   <= msprfp_pkg::FLEN_W'(exp_len_ff);
         out_idx_ff   <= msprfp_pkg::BIDX_W'(rd_idx_ff);
         out_byte_ff  <= is_empty ? '0 : rd_data_ff;
         out_empty_ff <= is_empty;
         out_last_ff  <= is_last;
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_command      = out_cmd_ff;
   assign rsp_frame_length = out_len_ff;
   assign rsp_byte_index   = out_idx_ff;
   assign rsp_payload_byte = out_byte_ff;
   assign rsp_empty_frame  = out_empty_ff;
   assign rsp_last         = out_last_ff;

`ifndef NO_ASSERTIONS
   a_nonlast_holds_input: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> req_stall)
      else $error("non-final result pending while input is open");

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_empty_frame |-> rsp_last && rsp_payload_byte == '0)
      else $error("empty frame result not final or nonzero");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last && !rsp_empty_frame |->
         (msprfp_pkg::FLEN_W'(rsp_byte_index) + msprfp_pkg::FLEN_W'(1)) == rsp_frame_length)
      else $error("final result index does not match frame length");

   a_emit_follows_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_EMIT_RD |=> state_ff == ST_EMIT_LD)
      else $error("memory read not followed by load state");
`endif

endmodule

`default_nettype wire
